### design/vertex_normal_decode_transform_assert.svh
// Assertion macros shared by the vertex transform pipeline modules.
// Expects clk and rst in the scope of each use.
`ifndef VERTEX_NORMAL_DECODE_TRANSFORM_ASSERT_SVH
`define VERTEX_NORMAL_DECODE_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define VNDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VNDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/vndt_pkg.sv
// Types, sine table and helpers for the vertex normal decode / transform block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vndt_pkg;

  localparam int QSINE_N = 65;

  // quarter wave of sin(k*pi/128), Q1.14
  localparam logic [14:0] QSINE [QSINE_N] = '{
    15'd0, 15'd402, 15'd804, 15'd1205, 15'd1606, 15'd2006, 15'd2404, 15'd2801,
    15'd3196, 15'd3590, 15'd3981, 15'd4370, 15'd4756, 15'd5139, 15'd5520,
    15'd5897, 15'd6270, 15'd6639, 15'd7005, 15'd7366, 15'd7723, 15'd8076,
    15'd8423, 15'd8765, 15'd9102, 15'd9434, 15'd9760, 15'd10080, 15'd10394,
    15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
    15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623,
    15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811,
    15'd14978, 15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679,
    15'd15791, 15'd15893, 15'd15986, 15'd16069, 15'd16143, 15'd16207,
    15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379, 15'd16384
  };

  localparam logic signed [16:0] V_ONE = 17'sd4096;

  // register indexes
  localparam logic [2:0] REG_SWAP_YZ    = 3'd0;
  localparam logic [2:0] REG_FLIP_V     = 3'd1;
  localparam logic [2:0] REG_USE_TAG    = 3'd2;
  localparam logic [2:0] REG_TAG_ROW_X  = 3'd3;
  localparam logic [2:0] REG_TAG_ROW_Y  = 3'd4;
  localparam logic [2:0] REG_TAG_ROW_Z  = 3'd5;
  localparam logic [2:0] REG_TAG_ORIGIN = 3'd6;

  typedef struct packed {
    logic              swap_yz;
    logic              flip_v;
    logic              use_tag;
    logic [2:0][2:0][15:0] coef;    // [row][col], signed Q1.14
    logic [2:0][19:0]  origin;      // signed, 1/64 units
  } cfg_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] normal_code;
    logic [15:0] tex_s;
    logic [15:0] tex_t;
    logic        last;
  } vin_t;

  typedef struct packed {
    logic [2:0][15:0] pos;
    logic [2:0][15:0] nrm;          // signed Q.14
    logic [15:0]      tex_s;
    logic [15:0]      tex_t;
    logic             last;
  } vtx_t;

  typedef struct packed {
    logic [20:0] out_x;
    logic [20:0] out_y;
    logic [20:0] out_z;
    logic [17:0] norm_x;
    logic [17:0] norm_y;
    logic [17:0] norm_z;
    logic [15:0] tex_u;
    logic [16:0] tex_v;
    logic        last;
  } res_t;

  function automatic logic signed [15:0] table_sin(input logic [7:0] k);
    logic [7:0]         idx;
    logic               neg;
    logic signed [15:0] mag;
    if (k <= 8'd64) begin
      idx = k;
      neg = 1'b0;
    end else if (k <= 8'd128) begin
      idx = 8'd128 - k;
      neg = 1'b0;
    end else if (k <= 8'd192) begin
      idx = k - 8'd128;
      neg = 1'b1;
    end else begin
      idx = 8'd0 - k;
      neg = 1'b1;
    end
    mag = $signed({1'b0, QSINE[idx[6:0]]});
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [15:0] table_cos(input logic [7:0] k);
    return table_sin(k + 8'd64);
  endfunction

endpackage

`default_nettype wire

### design/vertex_normal_decode_transform.sv
// Top level: config registers, normal decode and rotate pipeline segments.
// Uses vndt_pkg, vndt_normal_dec and vndt_rotate.
//
//  channel   dir  handshake                    word
//  s_axis    in   s_axis_tvalid/tready         pos, normal code, tex; tlast=last_vertex
//  m_axis    out  m_axis_tvalid/tready         position, normal, tex; tlast=last_out
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One word per cycle sustained while m_axis_tready is high; stages in order are lookup,
// normal product, rotate products, row sums, origin/saturate output register.
// Each stage holds its own valid bit and advances when the next one is empty
// or moving, so bubbles close up under output stall.
// Synchronous reset clears valid bits and loads the register defaults.
// cfg_ready is always high; unknown indexes are dropped.
`timescale 1ns / 1ps
`default_nettype none

module vertex_normal_decode_transform import vndt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, normal_code, tex_s, tex_t (16 bits each)
  input  logic [95:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z (21), norm_x, norm_y, norm_z (18), tex_u (16),
  // tex_v (17), 2 zero bits
  output logic [151:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic        swap_yz, flip_v, use_tag;
  logic [47:0] tag_row_x, tag_row_y, tag_row_z;
  logic [59:0] tag_origin;
  cfg_t        cfg;
  vin_t        vin;
  vtx_t        vtx;
  res_t        res;
  logic        mid_valid, mid_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_yz    <= 1'b1;
      flip_v     <= 1'b1;
      use_tag    <= 1'b0;
      tag_row_x  <= 48'h0000_0000_4000;
      tag_row_y  <= 48'h0000_4000_0000;
      tag_row_z  <= 48'h4000_0000_0000;
      tag_origin <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SWAP_YZ:    swap_yz    <= cfg_data[0];
        REG_FLIP_V:     flip_v     <= cfg_data[0];
        REG_USE_TAG:    use_tag    <= cfg_data[0];
        REG_TAG_ROW_X:  tag_row_x  <= cfg_data[47:0];
        REG_TAG_ROW_Y:  tag_row_y  <= cfg_data[47:0];
        REG_TAG_ROW_Z:  tag_row_z  <= cfg_data[47:0];
        REG_TAG_ORIGIN: tag_origin <= cfg_data[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.swap_yz = swap_yz;
    cfg.flip_v  = flip_v;
    cfg.use_tag = use_tag;
    cfg.coef[0] = {tag_row_x[47:32], tag_row_x[31:16], tag_row_x[15:0]};
    cfg.coef[1] = {tag_row_y[47:32], tag_row_y[31:16], tag_row_y[15:0]};
    cfg.coef[2] = {tag_row_z[47:32], tag_row_z[31:16], tag_row_z[15:0]};
    cfg.origin  = {tag_origin[59:40], tag_origin[39:20], tag_origin[19:0]};
  end

  always_comb begin
    vin.pos_x       = s_axis_tdata[15:0];
    vin.pos_y       = s_axis_tdata[31:16];
    vin.pos_z       = s_axis_tdata[47:32];
    vin.normal_code = s_axis_tdata[63:48];
    vin.tex_s       = s_axis_tdata[79:64];
    vin.tex_t       = s_axis_tdata[95:80];
    vin.last        = s_axis_tlast;
  end

  vndt_normal_dec u_normal_dec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (vin),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (vtx)
  );

  vndt_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (vtx),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {2'b00, res.tex_v, res.tex_u, res.norm_z, res.norm_y,
                         res.norm_x, res.out_z, res.out_y, res.out_x};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

### design/vndt_normal_dec.sv
// Normal decode: two stages, table lookup then lat/lng products with rounding.
// Uses vndt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_normal_decode_transform_assert.svh"

module vndt_normal_dec import vndt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  vin_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output vtx_t out_data
);

  logic               v1, v2, adv1, adv2;
  logic [2:0][15:0]   pos1;
  logic [15:0]        tex_s1, tex_t1;
  logic               last1;
  logic signed [15:0] clat, slat, slng, clng;
  logic signed [31:0] px, py;
  logic signed [31:0] rx, ry;
  vtx_t               s2;
  logic               nrm_ok;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      pos1   <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
      tex_s1 <= in_data.tex_s;
      tex_t1 <= in_data.tex_t;
      last1  <= in_data.last;
      clat   <= table_cos(in_data.normal_code[15:8]);
      slat   <= table_sin(in_data.normal_code[15:8]);
      slng   <= table_sin(in_data.normal_code[7:0]);
      clng   <= table_cos(in_data.normal_code[7:0]);
    end
  end

  always_comb begin
    px = clat * slng;
    py = slat * slng;
    rx = px + 32'sd8192;
    ry = py + 32'sd8192;
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      s2.pos    <= pos1;
      s2.nrm[0] <= rx[29:14];
      s2.nrm[1] <= ry[29:14];
      s2.nrm[2] <= clng;
      s2.tex_s  <= tex_s1;
      s2.tex_t  <= tex_t1;
      s2.last   <= last1;
    end
  end

  assign out_valid = v2;
  assign out_data  = s2;

  assign nrm_ok = ($signed(s2.nrm[0]) >= -16'sd16384) && ($signed(s2.nrm[0]) <= 16'sd16384) &&
                  ($signed(s2.nrm[1]) >= -16'sd16384) && ($signed(s2.nrm[1]) <= 16'sd16384);

  `VNDT_ASSERT_IMP(a_nrm_unit, v2, nrm_ok, "decoded normal out of unit range")
  `VNDT_ASSERT_NXT(a_fill, v1 && !v2, v2, "decode word lost between stages")

endmodule

`default_nettype wire

### design/vndt_rotate.sv
// Rotation and origin (applied when use_tag is set): products, sums with rounding,
// then origin, saturation, axis swap and texture flip into the output register. Uses vndt_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_normal_decode_transform_assert.svh"

module vndt_rotate import vndt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  vtx_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic               v3, v4, v5, adv3, adv4, adv5;
  logic signed [31:0] pp [3][3];
  logic signed [31:0] pn [3][3];
  logic [2:0][15:0]   p3, n3;
  logic [15:0]        tex_s3, tex_t3, tex_s4, tex_t4;
  logic               last3, last4;
  logic signed [19:0] sp4 [3];
  logic signed [19:0] sn4 [3];
  logic signed [33:0] accp [3];
  logic signed [33:0] accn [3];
  logic signed [21:0] rp [3];
  logic signed [20:0] sat_p [3];
  logic signed [17:0] sat_n [3];
  logic signed [16:0] tv;
  res_t               res, res_next;

  assign adv5     = !v5 || out_ready;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign in_ready = adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv3) v3 <= in_valid;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // stage 3: nine position and nine normal products
  always_ff @(posedge clk) begin
    if (adv3 && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp[i][j] <= $signed(cfg.coef[i][j]) * $signed(in_data.pos[j]);
          pn[i][j] <= $signed(cfg.coef[i][j]) * $signed(in_data.nrm[j]);
        end
      end
      p3     <= in_data.pos;
      n3     <= in_data.nrm;
      tex_s3 <= in_data.tex_s;
      tex_t3 <= in_data.tex_t;
      last3  <= in_data.last;
    end
  end

  // stage 4: row sums, round half up, when use_tag is set; else the inputs pass through
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      accp[i] = pp[i][0] + pp[i][1] + pp[i][2] + 34'sd8192;
      accn[i] = pn[i][0] + pn[i][1] + pn[i][2] + 34'sd8192;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      for (int i = 0; i < 3; i++) begin
        if (cfg.use_tag) begin
          sp4[i] <= accp[i][33:14];
          sn4[i] <= accn[i][33:14];
        end else begin
          sp4[i] <= 20'($signed(p3[i]));
          sn4[i] <= 20'($signed(n3[i]));
        end
      end
      tex_s4 <= tex_s3;
      tex_t4 <= tex_t3;
      last4  <= last3;
    end
  end

  // stage 5: origin, saturate, swap, texture
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rp[i] = 22'(sp4[i]);
      if (cfg.use_tag) rp[i] = rp[i] + 22'($signed(cfg.origin[i]));
      if (rp[i] > 22'sd1048575)       sat_p[i] = 21'sd1048575;
      else if (rp[i] < -22'sd1048576) sat_p[i] = -21'sd1048576;
      else                            sat_p[i] = rp[i][20:0];
      if (sn4[i] > 20'sd131071)       sat_n[i] = 18'sd131071;
      else if (sn4[i] < -20'sd131072) sat_n[i] = -18'sd131072;
      else                            sat_n[i] = sn4[i][17:0];
    end
    tv = 17'($signed(tex_t4));
    if (cfg.flip_v) tv = V_ONE - tv;
    res_next.out_x  = sat_p[0];
    res_next.norm_x = sat_n[0];
    if (cfg.swap_yz) begin
      res_next.out_y  = sat_p[2];
      res_next.out_z  = sat_p[1];
      res_next.norm_y = sat_n[2];
      res_next.norm_z = sat_n[1];
    end else begin
      res_next.out_y  = sat_p[1];
      res_next.out_z  = sat_p[2];
      res_next.norm_y = sat_n[1];
      res_next.norm_z = sat_n[2];
    end
    res_next.tex_u = tex_s4;
    res_next.tex_v = tv;
    res_next.last  = last4;
  end

  always_ff @(posedge clk) begin
    if (adv5 && v4) res <= res_next;
  end

  assign out_valid = v5;
  assign out_data  = res;

  `VNDT_ASSERT_IMP(a_drain_ready, !v5, in_ready, "empty output yet pipeline not ready")
  `VNDT_ASSERT_IMP(a_out_source, $rose(v5), $past(v4), "output word without a source")
  `VNDT_ASSERT_NXT(a_adv_out, v4 && !v5, v5, "sum stage word not moved to output")

endmodule

`default_nettype wire
